/* hw/rtl/poli_pkg.sv */
// ---------------------------------------------------------------------------
// Positional ordered list package
// Shared widths, operation and status codes, and the cell control word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package poli_pkg;

   // Default sizing handed to the top level.
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the request and response words.
   localparam int MODE_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 5;
   localparam int COUNT_W  = 5;

   // Operation codes carried in the request word.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_LOCATE = 2'd3
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

/* hw/rtl/poli_ifs.sv */
// ---------------------------------------------------------------------------
// Positional ordered list channels
// Valid/ready channels for the request word and the response word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface poli_req_if;
   logic                               valid;
   logic                               ready;
   logic        [poli_pkg::MODE_W-1:0]  mode;
   logic        [poli_pkg::POS_W-1:0]   position;
   logic signed [poli_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface poli_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [poli_pkg::STATUS_W-1:0] status;
   logic signed [poli_pkg::VALUE_W-1:0]  data_out;
   logic        [poli_pkg::FOUND_W-1:0]  found_at;
   logic        [poli_pkg::COUNT_W-1:0]  count;
   logic                                is_empty;

   modport source (output valid, output status, output data_out, output found_at,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input data_out, input found_at,
                   input count, input is_empty, output ready);
endinterface

/* hw/rtl/poli_cell.sv */
// ---------------------------------------------------------------------------
// Positional ordered list cell
// Holds one entry; shifts from its neighbours on insert and delete and
// compares its entry against the search value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module poli_cell #(
   parameter int DATA_WIDTH = poli_pkg::DATA_WIDTH_DEF,
   parameter int CMP_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  poli_pkg::cell_ctl_type ctl,
   input  logic [CMP_W-1:0]       k_idx,
   input  logic [CMP_W-1:0]       fill,
   input  logic [DATA_WIDTH-1:0]  new_data,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  entry_data,
   output logic                   match
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   // Insert opens a gap at the target, delete closes it.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && (MY_IDX > k_idx)) begin
         entry_in = left_data;
      end else if (ctl.insert && (MY_IDX == k_idx)) begin
         entry_in = new_data;
      end else if (ctl.remove && (MY_IDX >= k_idx)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Only cells inside the filled region may report a hit.
   assign match      = (MY_IDX < fill) && (entry_ff == new_data);
   assign entry_data = entry_ff;

endmodule

/* hw/rtl/poli_first.sv */
// ---------------------------------------------------------------------------
// Positional ordered list first-hit encoder
// Turns the registered hit vector into the 1-based position of the lowest
// hit, or zero when there is none.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module poli_first #(
   parameter int CAPACITY = poli_pkg::CAPACITY_DEF,
   parameter int CNT_W    = 5
) (
   input  logic [CAPACITY-1:0] hits,
   output logic [CNT_W-1:0]    first_pos
);

   // Scan from the top so that the lowest hit wins.
   always_comb begin
      first_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hits[i]) begin
            first_pos = CNT_W'(i + 1);
         end
      end
   end

endmodule

/* hw/rtl/positional_ordered_list.sv */
// An accepted word passes through the encode stage and the response register to
// the response channel. Throughput: one word per cycle while responses are
// taken; the cell chain updates every entry in the accept cycle and the hit
// vector is encoded in the following stage. Reset (synchronous, active high)
// empties the list and clears both pipeline stages; entry storage is not cleared.
// ---------------------------------------------------------------------------
// Positional ordered list
// A chain of shifting cells holding an ordered list with insert, delete,
// get and locate by position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_ordered_list #(
   parameter int CAPACITY   = poli_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = poli_pkg::DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   poli_req_if.sink   req_ch,
   poli_rsp_if.source rsp_ch
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > poli_pkg::POS_W) ? CNT_W : poli_pkg::POS_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // Cell chain wiring.
   poli_pkg::cell_ctl_type ctl;
   logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
   logic [CAPACITY-1:0]    cell_match;
   logic [DATA_WIDTH-1:0]  new_data;

   // List length.
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;

   // Decode stage signals.
   logic                      accept;
   logic                      b_adv;
   poli_pkg::mode_type        mode;
   logic [poli_pkg::POS_W-1:0] k_pos;
   logic [CMP_W-1:0]          k_idx;
   logic [CMP_W-1:0]          fill_cmp;
   poli_pkg::status_type      status_a;
   logic [DATA_WIDTH-1:0]     data_a;
   logic                      ins_a;
   logic                      del_a;
   logic [CNT_W-1:0]          fill_a;

   // Encode stage registers.
   logic                      b_valid_ff;
   logic                      b_valid_in;
   poli_pkg::status_type      b_status_ff;
   logic [DATA_WIDTH-1:0]     b_data_ff;
   logic [CNT_W-1:0]          b_fill_ff;
   logic                      b_locate_ff;
   logic [CAPACITY-1:0]       b_hits_ff;
   logic [CNT_W-1:0]          first_pos;
   logic [CMP_W-1:0]          first_wide;
   logic [CMP_W-1:0]          b_fill_wide;

   // Response registers.
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [poli_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [poli_pkg::VALUE_W-1:0]      rsp_data_ff;
   logic [poli_pkg::FOUND_W-1:0]      rsp_found_ff;
   logic [poli_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic                              rsp_empty_ff;

   // Handshake: the encode stage drains into the response register.
   assign b_adv        = b_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !b_valid_ff || b_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   // Request decode: position 0 and 1 both mean the head.
   assign mode     = poli_pkg::mode_type'(req_ch.mode);
   assign k_pos    = (req_ch.position <= poli_pkg::POS_W'(1)) ? '0
                     : req_ch.position - poli_pkg::POS_W'(1);
   assign k_idx    = CMP_W'(k_pos);
   assign fill_cmp = CMP_W'(fill_ff);
   assign new_data = DATA_WIDTH'($unsigned(req_ch.value));

   // Range checks and the operation chosen for the cells.
   always_comb begin
      status_a = poli_pkg::ST_OK;
      data_a   = '0;
      ins_a    = 1'b0;
      del_a    = 1'b0;
      fill_a   = fill_ff;
      unique case (mode)
         poli_pkg::MODE_INSERT: begin
            if (k_idx > fill_cmp) begin
               status_a = poli_pkg::ST_RANGE;
            end else if (fill_ff == FULL_CNT) begin
               status_a = poli_pkg::ST_FULL;
            end else begin
               ins_a  = 1'b1;
               fill_a = fill_ff + CNT_W'(1);
            end
         end
         poli_pkg::MODE_DELETE: begin
            if (k_idx >= fill_cmp) begin
               status_a = poli_pkg::ST_RANGE;
            end else begin
               del_a  = 1'b1;
               data_a = cell_data[k_idx[IDX_W-1:0]];
               fill_a = fill_ff - CNT_W'(1);
            end
         end
         poli_pkg::MODE_GET: begin
            if (k_idx >= fill_cmp) begin
               status_a = poli_pkg::ST_RANGE;
            end else begin
               data_a = cell_data[k_idx[IDX_W-1:0]];
            end
         end
         poli_pkg::MODE_LOCATE: begin
            status_a = poli_pkg::ST_OK;
         end
         default: begin
            status_a = poli_pkg::ST_OK;
         end
      endcase
   end

   assign ctl.insert = accept && ins_a;
   assign ctl.remove = accept && del_a;
   assign fill_in    = accept ? fill_a : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // The chain of cells; the end cells see their own entry beyond the edge.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (g == 0) begin : g_head
         assign left_d = cell_data[g];
      end else begin : g_body
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_d = cell_data[g];
      end else begin : g_next
         assign right_d = cell_data[g+1];
      end
      poli_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CMP_W      (CMP_W),
         .INDEX      (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .k_idx      (k_idx),
         .fill       (fill_cmp),
         .new_data   (new_data),
         .left_data  (left_d),
         .right_data (right_d),
         .entry_data (cell_data[g]),
         .match      (cell_match[g])
      );
   end

   // Encode stage: capture the result of the accepted word.
   assign b_valid_in = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_status_ff <= status_a;
         b_data_ff   <= data_a;
         b_fill_ff   <= fill_a;
         b_locate_ff <= (mode == poli_pkg::MODE_LOCATE);
         b_hits_ff   <= cell_match;
      end
   end

   poli_first #(
      .CAPACITY  (CAPACITY),
      .CNT_W     (CNT_W)
   ) u_first (
      .hits      (b_hits_ff),
      .first_pos (first_pos)
   );

   assign first_wide  = CMP_W'(first_pos);
   assign b_fill_wide = CMP_W'(b_fill_ff);

   // Response register.
   assign rsp_valid_in = b_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_status_ff <= b_status_ff;
         rsp_data_ff   <= poli_pkg::VALUE_W'(b_data_ff);
         rsp_found_ff  <= b_locate_ff ? first_wide[poli_pkg::FOUND_W-1:0] : '0;
         rsp_count_ff  <= b_fill_wide[poli_pkg::COUNT_W-1:0];
         rsp_empty_ff  <= (b_fill_ff == '0);
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.data_out = $signed(rsp_data_ff);
   assign rsp_ch.found_at = rsp_found_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.is_empty = rsp_empty_ff;

endmodule

/* tb/positional_ordered_list_tb.sv */
// ---------------------------------------------------------------------------
// Positional ordered list testbench
// Drives insert, delete, get and locate words into the list, predicts every
// response word with a scoreboard that holds its own copy of the list, and
// checks each response field by field under several patterns of idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_ordered_list_tb;

   localparam int CAPACITY     = poli_pkg::CAPACITY_DEF;
   localparam int QUIET_LIMIT  = 4000;
   localparam int TREND_ITEMS  = 48;
   localparam int PHASE_ITEMS  = 482;
   localparam int DRAIN_CYCLES = 8;

   localparam logic signed [poli_pkg::VALUE_W-1:0] VALUE_MIN =
      {1'b1, {(poli_pkg::VALUE_W-1){1'b0}}};
   localparam logic signed [poli_pkg::VALUE_W-1:0] VALUE_MAX =
      {1'b0, {(poli_pkg::VALUE_W-1){1'b1}}};

   // One predicted response word.
   typedef struct {
      poli_pkg::status_type                status;
      logic signed [poli_pkg::VALUE_W-1:0] data_out;
      logic [poli_pkg::FOUND_W-1:0]        found_at;
      logic [poli_pkg::COUNT_W-1:0]        count;
      logic                                is_empty;
   } list_result_type;

   // Direction in which the random traffic pushes the list length.
   typedef enum {TREND_GROW, TREND_SHRINK, TREND_EVEN} trend_type;

   // Scoreboard: keeps a copy of the list and a queue of predicted responses.
   class list_scoreboard;
      logic signed [poli_pkg::VALUE_W-1:0] slots [CAPACITY];
      int unsigned                         fill;
      list_result_type                     expected_q [$];
      int unsigned                         failures;

      function new();
         fill     = 0;
         failures = 0;
      endfunction

      // Applies an accepted request word to the list and queues its response.
      function void note_request(poli_pkg::mode_type mode,
                                 logic [poli_pkg::POS_W-1:0] position,
                                 logic signed [poli_pkg::VALUE_W-1:0] value);
         int unsigned     idx;
         list_result_type r;
         idx = (position <= 1) ? 0 : int'(position) - 1;
         r   = '{poli_pkg::ST_OK, '0, '0, '0, 1'b0};
         case (mode)
            poli_pkg::MODE_INSERT: begin
               if (idx > fill) begin
                  r.status = poli_pkg::ST_RANGE;
               end else if (fill >= CAPACITY) begin
                  r.status = poli_pkg::ST_FULL;
               end else begin
                  for (int i = fill; i > idx; i--) slots[i] = slots[i-1];
                  slots[idx] = value;
                  fill++;
               end
            end
            poli_pkg::MODE_DELETE: begin
               if (idx >= fill) begin
                  r.status = poli_pkg::ST_RANGE;
               end else begin
                  r.data_out = slots[idx];
                  for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            poli_pkg::MODE_GET: begin
               if (idx >= fill) r.status = poli_pkg::ST_RANGE;
               else r.data_out = slots[idx];
            end
            default: begin
               // The first matching entry wins.
               for (int i = 0; i < fill; i++) begin
                  if (slots[i] == value && r.found_at == 0)
                     r.found_at = poli_pkg::FOUND_W'(i + 1);
               end
            end
         endcase
         r.count    = poli_pkg::COUNT_W'(fill);
         r.is_empty = (fill == 0);
         expected_q.push_back(r);
      endfunction

      // Compares a response word with the oldest prediction.
      function void check_response(list_result_type got);
         list_result_type exp;
         if (expected_q.size() == 0) begin
            $error("Response word arrived with no request outstanding");
            failures++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            failures++;
         end
         if (got.data_out !== exp.data_out) begin
            $error("data_out: expected %0d, got %0d", exp.data_out, got.data_out);
            failures++;
         end
         if (got.found_at !== exp.found_at) begin
            $error("found_at: expected %0d, got %0d", exp.found_at, got.found_at);
            failures++;
         end
         if (got.count !== exp.count) begin
            $error("count: expected %0d, got %0d", exp.count, got.count);
            failures++;
         end
         if (got.is_empty !== exp.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   bit   running;
   int   quiet_cycles;

   list_scoreboard sb = new();

   poli_req_if req_ch ();
   poli_rsp_if rsp_ch ();

   positional_ordered_list DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sends one request word, idling first at the current sender rate.
   task automatic send_word(input poli_pkg::mode_type mode,
                            input logic [poli_pkg::POS_W-1:0] position,
                            input logic signed [poli_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.position <= position;
      req_ch.value    <= value;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, position, value);
      @(negedge clock);
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   // Picks a value: often from a small pool so that duplicates and hits are common.
   function automatic logic signed [poli_pkg::VALUE_W-1:0] pick_value();
      int sel;
      int v;
      sel = $urandom_range(99, 0);
      if (sel < 40) begin
         v = $urandom_range(6, 0);
         return v - 3;
      end else if (sel < 50) begin
         case ($urandom_range(3, 0))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return -1;
            default: return 0;
         endcase
      end
      return $signed($urandom);
   endfunction

   // Random traffic, with the length steered up or down in stretches.
   task automatic run_phase(input int items, input int idle, input int stall);
      trend_type                           trend;
      int                                  r;
      poli_pkg::mode_type                  mode;
      logic [poli_pkg::POS_W-1:0]          position;
      logic signed [poli_pkg::VALUE_W-1:0] value;
      idle_pct  = idle;
      stall_pct = stall;
      trend     = TREND_EVEN;
      for (int n = 0; n < items; n++) begin
         if (n % TREND_ITEMS == 0) trend = trend_type'($urandom_range(2, 0));
         r = $urandom_range(99, 0);
         case (trend)
            TREND_GROW:   mode = (r < 55) ? poli_pkg::MODE_INSERT :
                                 (r < 65) ? poli_pkg::MODE_DELETE :
                                 (r < 82) ? poli_pkg::MODE_GET : poli_pkg::MODE_LOCATE;
            TREND_SHRINK: mode = (r < 20) ? poli_pkg::MODE_INSERT :
                                 (r < 60) ? poli_pkg::MODE_DELETE :
                                 (r < 80) ? poli_pkg::MODE_GET : poli_pkg::MODE_LOCATE;
            default:      mode = (r < 35) ? poli_pkg::MODE_INSERT :
                                 (r < 60) ? poli_pkg::MODE_DELETE :
                                 (r < 80) ? poli_pkg::MODE_GET : poli_pkg::MODE_LOCATE;
         endcase

         // Positions are mostly in range, sometimes anywhere in the field.
         if ($urandom_range(99, 0) < 20)
            position = poli_pkg::POS_W'($urandom_range(31, 0));
         else if (mode == poli_pkg::MODE_INSERT)
            position = poli_pkg::POS_W'($urandom_range(sb.fill + 1, 0));
         else
            position = poli_pkg::POS_W'($urandom_range(sb.fill, 0));

         // A locate usually searches for a value that is in the list.
         if (mode == poli_pkg::MODE_LOCATE && sb.fill > 0 && $urandom_range(99, 0) < 60)
            value = sb.slots[$urandom_range(sb.fill - 1, 0)];
         else
            value = pick_value();

         send_word(mode, position, value);
      end
      drain_responses();
   endtask

   // Response side: ready changes on the falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // Response check on every accepted response word.
   always @(posedge clock) begin : rsp_monitor
      list_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{poli_pkg::status_type'(rsp_ch.status), rsp_ch.data_out,
                 rsp_ch.found_at, rsp_ch.count, rsp_ch.is_empty};
         sb.check_response(got);
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (running) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Main sequence: reset, directed words, random phases, drain and verdict.
   initial begin
      reset           = 1'b1;
      running         = 1'b0;
      quiet_cycles    = 0;
      idle_pct        = 0;
      stall_pct       = 0;
      req_ch.valid    = 1'b0;
      req_ch.mode     = poli_pkg::MODE_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      running <= 1'b1;
      @(negedge clock);

      // Directed: empty list, head and tail inserts, extremes and range errors.
      send_word(poli_pkg::MODE_LOCATE, 5'd0,  32'sd5);
      send_word(poli_pkg::MODE_GET,    5'd0,  32'sd0);
      send_word(poli_pkg::MODE_DELETE, 5'd1,  32'sd0);
      send_word(poli_pkg::MODE_INSERT, 5'd2,  32'sd7);
      send_word(poli_pkg::MODE_INSERT, 5'd0,  VALUE_MIN);
      send_word(poli_pkg::MODE_INSERT, 5'd1,  VALUE_MAX);
      send_word(poli_pkg::MODE_INSERT, 5'd3,  -32'sd1);
      send_word(poli_pkg::MODE_INSERT, 5'd31, 32'sd0);
      send_word(poli_pkg::MODE_INSERT, 5'd2,  32'sd0);
      send_word(poli_pkg::MODE_INSERT, 5'd5,  32'sd0);
      send_word(poli_pkg::MODE_GET,    5'd0,  32'sd0);
      send_word(poli_pkg::MODE_GET,    5'd5,  32'sd0);
      send_word(poli_pkg::MODE_GET,    5'd6,  32'sd0);
      send_word(poli_pkg::MODE_LOCATE, 5'd31, 32'sd0);
      send_word(poli_pkg::MODE_LOCATE, 5'd0,  VALUE_MIN);
      send_word(poli_pkg::MODE_LOCATE, 5'd0,  32'sd12345);
      send_word(poli_pkg::MODE_DELETE, 5'd3,  32'sd0);
      send_word(poli_pkg::MODE_DELETE, 5'd4,  32'sd0);
      send_word(poli_pkg::MODE_DELETE, 5'd31, 32'sd0);
      send_word(poli_pkg::MODE_DELETE, 5'd0,  32'sd0);
      send_word(poli_pkg::MODE_GET,    5'd31, 32'sd0);
      drain_responses();

      // Random phases: no idling, idle sender, stalling receiver, both.
      run_phase(PHASE_ITEMS, 0, 0);
      run_phase(PHASE_ITEMS, 84, 0);
      run_phase(PHASE_ITEMS, 0, 84);
      run_phase(PHASE_ITEMS, 30, 30);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* positional_ordered_list.f */
hw/rtl/poli_pkg.sv
hw/rtl/poli_ifs.sv
hw/rtl/poli_cell.sv
hw/rtl/poli_first.sv
hw/rtl/positional_ordered_list.sv
tb/positional_ordered_list_tb.sv
